[rtl/srsw_pkg.sv]
// ---------------------------------------------------------------------------
// srsw_pkg: shared types and constants of the selective-repeat sender window
// Beat layouts, command and reason codes, ALU opcodes, reset values and the
// small sequence-number helper.
// ---------------------------------------------------------------------------
`default_nettype none

package srsw_pkg;

  // field widths
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned SEQ_W   = 4;
  localparam int unsigned LEN_W   = 8;
  localparam int unsigned AGE_W   = 16;
  localparam int unsigned BYTES_W = 32;
  localparam int unsigned OCC_W   = 3;
  localparam int unsigned WSZ_W   = 3;
  localparam int unsigned TMO_W   = 16;
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned CFG_A_W = 1;
  localparam int unsigned ALU_W   = 32;

  // default ring depth
  localparam int unsigned WIN_MAX_DEF = 4;

  // reset values
  localparam logic [WSZ_W-1:0] WINDOW_RST  = 3'd3;
  localparam logic [TMO_W-1:0] TIMEOUT_RST = 16'd1;
  // modulus of the reset window minus one, so the first frame gets 0
  localparam logic [SEQ_W-1:0] LAST_SEQ_RST = 4'd6;
  localparam logic [AGE_W-1:0] AGE_MAX = '1;

  // configuration register indexes
  localparam logic [CFG_A_W-1:0] REG_WIN_SLOTS     = 1'b0;
  localparam logic [CFG_A_W-1:0] REG_TIMEOUT_TICKS = 1'b1;

  // event commands
  typedef enum logic [CMD_W-1:0] {
    CMD_OFFER = 2'd0,
    CMD_ACK   = 2'd1,
    CMD_NACK  = 2'd2,
    CMD_TICK  = 2'd3
  } cmd_t;

  // transmit reasons
  localparam logic [1:0] WHY_FIRST   = 2'd0;
  localparam logic [1:0] WHY_NACK    = 2'd1;
  localparam logic [1:0] WHY_TIMEOUT = 2'd2;

  // result kinds
  localparam logic KIND_TX     = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // shared unit opcodes
  typedef enum logic [2:0] {
    OP_EQ       = 3'd0,
    OP_GT       = 3'd1,
    OP_INC_AGE  = 3'd2,
    OP_ADD_SAT  = 3'd3,
    OP_SEQ_NEXT = 3'd4
  } alu_op_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [SEQ_W-1:0] seq;
    logic [LEN_W-1:0] frame_len;
  } item_t;

  typedef struct packed {
    logic               kind;
    logic [SEQ_W-1:0]   tx_seq;
    logic [1:0]         reason;
    logic               accepted;
    logic [OCC_W-1:0]   occupancy;
    logic [BYTES_W-1:0] bytes_done;
    logic               last;
  } result_t;

  typedef struct packed {
    logic [WSZ_W-1:0] win_slots;
    logic [TMO_W-1:0] timeout_ticks;
  } cfg_t;

  typedef struct packed {
    alu_op_t          op;
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [ALU_W-1:0] res;
    logic             flag;
  } alu_rsp_t;

  // (v + 1) mod m for v below 16 and m odd, at least 3
  function automatic logic [SEQ_W-1:0] seq_next(input logic [SEQ_W-1:0] v,
                                                input logic [SEQ_W-1:0] m);
    logic [SEQ_W:0] x;
    x = {1'b0, v} + 5'd1;
    for (int i = 0; i < 6; i++) begin
      if (x >= {1'b0, m}) begin
        x = x - {1'b0, m};
      end
    end
    return x[SEQ_W-1:0];
  endfunction

endpackage

`default_nettype wire

[rtl/srsw_alu.sv]
// ---------------------------------------------------------------------------
// srsw_alu: shared arithmetic and compare unit
// One compare, saturating add/increment or sequence step per cycle, as the
// sequencer asks.
// ---------------------------------------------------------------------------
`default_nettype none

module srsw_alu (
  input  srsw_pkg::alu_req_t req,
  output srsw_pkg::alu_rsp_t rsp
);

  logic [srsw_pkg::ALU_W:0]       sum;
  logic [srsw_pkg::AGE_W-1:0]     age;

  assign sum = {1'b0, req.a} + {1'b0, req.b};
  assign age = req.a[srsw_pkg::AGE_W-1:0];

  // one operation per cycle
  always_comb begin
    rsp.res  = '0;
    rsp.flag = 1'b0;
    unique case (req.op)
      srsw_pkg::OP_EQ: begin
        rsp.flag = (req.a == req.b);
      end
      srsw_pkg::OP_GT: begin
        rsp.flag = (req.a > req.b);
      end
      srsw_pkg::OP_INC_AGE: begin
        rsp.res = (age == srsw_pkg::AGE_MAX) ? srsw_pkg::ALU_W'(age)
                                             : srsw_pkg::ALU_W'(age) + 32'd1;
      end
      srsw_pkg::OP_ADD_SAT: begin
        rsp.res = sum[srsw_pkg::ALU_W] ? '1 : sum[srsw_pkg::ALU_W-1:0];
      end
      srsw_pkg::OP_SEQ_NEXT: begin
        rsp.res = srsw_pkg::ALU_W'(srsw_pkg::seq_next(req.a[srsw_pkg::SEQ_W-1:0],
                                                      req.b[srsw_pkg::SEQ_W-1:0]));
      end
      default: begin
        rsp.res  = '0;
        rsp.flag = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

[rtl/srsw_engine.sv]
// ---------------------------------------------------------------------------
// srsw_engine: slot ring and event sequencer
// Holds the window slots and walks them one slot a cycle through the apply,
// retire and send passes, driving the shared unit and the result register.
// ---------------------------------------------------------------------------
`default_nettype none

module srsw_engine #(
  parameter int unsigned WIN_MAX = srsw_pkg::WIN_MAX_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  srsw_pkg::item_t    item,
  input  srsw_pkg::cfg_t     cfg,
  output logic               busy,
  output srsw_pkg::alu_req_t alu_req,
  input  srsw_pkg::alu_rsp_t alu_rsp,
  output logic               result_valid,
  output srsw_pkg::result_t  result
);

  localparam int unsigned IW = (WIN_MAX > 1) ? $clog2(WIN_MAX) : 1;
  localparam int unsigned CW = $clog2(WIN_MAX + 1);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_OFFER  = 6'b000010,
    S_MARK   = 6'b000100,
    S_AGE    = 6'b001000,
    S_RETIRE = 6'b010000,
    S_SEND   = 6'b100000
  } state_t;

  state_t state;

  // slot ring
  logic [srsw_pkg::SEQ_W-1:0] slot_seq [WIN_MAX];
  logic [srsw_pkg::LEN_W-1:0] slot_len [WIN_MAX];
  logic [srsw_pkg::AGE_W-1:0] slot_age [WIN_MAX];
  logic [WIN_MAX-1:0]         slot_acked;
  logic [WIN_MAX-1:0]         slot_nacked;
  logic [WIN_MAX-1:0]         slot_sent;

  logic [IW-1:0]                head_index;
  logic [CW-1:0]                slot_count;
  logic [srsw_pkg::SEQ_W-1:0]   last_seq;
  logic [srsw_pkg::BYTES_W-1:0] retired_bytes;

  // latched event
  srsw_pkg::cmd_t             cmd_q;
  logic [srsw_pkg::SEQ_W-1:0] seq_q;
  logic [srsw_pkg::LEN_W-1:0] len_q;
  logic                       accepted;
  logic [CW-1:0]              k;

  logic [srsw_pkg::WSZ_W-1:0] win3;
  logic [CW-1:0]              win;
  logic [srsw_pkg::SEQ_W-1:0] modulus;
  logic [IW-1:0]              p;
  logic [IW-1:0]              p_tail;
  logic                       walk_done;
  logic                       due;
  logic [1:0]                 why;

  // ring index: head plus offset, wrapped at the ring depth
  function automatic logic [IW-1:0] ring_add(input logic [IW-1:0] h,
                                             input logic [IW-1:0] off);
    logic [IW:0] s;
    s = {1'b0, h} + {1'b0, off};
    if (s >= (IW+1)'(WIN_MAX)) begin
      s = s - (IW+1)'(WIN_MAX);
    end
    return s[IW-1:0];
  endfunction

  // effective window and sequence modulus
  always_comb begin
    if (cfg.win_slots == '0) begin
      win3 = 3'd1;
    end else if (int'(cfg.win_slots) > int'(WIN_MAX)) begin
      win3 = srsw_pkg::WSZ_W'(WIN_MAX);
    end else begin
      win3 = cfg.win_slots;
    end
  end
  assign win     = CW'(win3);
  assign modulus = {win3, 1'b1};

  assign p         = ring_add(head_index, k[IW-1:0]);
  assign p_tail    = ring_add(head_index, slot_count[IW-1:0]);
  assign walk_done = (k == slot_count);
  assign busy      = (state != S_IDLE);

  // shared unit request
  always_comb begin
    alu_req.op = srsw_pkg::OP_EQ;
    alu_req.a  = '0;
    alu_req.b  = '0;
    unique case (state)
      S_OFFER: begin
        alu_req.op = srsw_pkg::OP_SEQ_NEXT;
        alu_req.a  = srsw_pkg::ALU_W'(last_seq);
        alu_req.b  = srsw_pkg::ALU_W'(modulus);
      end
      S_MARK: begin
        alu_req.op = srsw_pkg::OP_EQ;
        alu_req.a  = srsw_pkg::ALU_W'(slot_seq[p]);
        alu_req.b  = srsw_pkg::ALU_W'(seq_q);
      end
      S_AGE: begin
        alu_req.op = srsw_pkg::OP_INC_AGE;
        alu_req.a  = srsw_pkg::ALU_W'(slot_age[p]);
      end
      S_RETIRE: begin
        alu_req.op = srsw_pkg::OP_ADD_SAT;
        alu_req.a  = retired_bytes;
        alu_req.b  = srsw_pkg::ALU_W'(slot_len[head_index]);
      end
      S_SEND: begin
        alu_req.op = srsw_pkg::OP_GT;
        alu_req.a  = srsw_pkg::ALU_W'(slot_age[p]);
        alu_req.b  = srsw_pkg::ALU_W'(cfg.timeout_ticks);
      end
      default: begin
        alu_req.op = srsw_pkg::OP_EQ;
      end
    endcase
  end

  // send decision for the slot under the walk pointer
  assign due = !slot_sent[p] || slot_nacked[p] || (alu_rsp.flag && !slot_acked[p]);
  always_comb begin
    priority if (!slot_sent[p]) begin
      why = srsw_pkg::WHY_FIRST;
    end else if (slot_nacked[p]) begin
      why = srsw_pkg::WHY_NACK;
    end else begin
      why = srsw_pkg::WHY_TIMEOUT;
    end
  end

  // slot payload: written on offer and walk updates, no reset needed
  always_ff @(posedge clk) begin
    if (state == S_OFFER && slot_count < win) begin
      slot_seq[p_tail] <= alu_rsp.res[srsw_pkg::SEQ_W-1:0];
      slot_len[p_tail] <= len_q;
      slot_age[p_tail] <= '0;
    end else if (state == S_AGE && !walk_done) begin
      slot_age[p] <= alu_rsp.res[srsw_pkg::AGE_W-1:0];
    end else if (state == S_RETIRE && slot_count != '0 && slot_acked[head_index]) begin
      slot_age[head_index] <= '0;
    end else if (state == S_SEND && !walk_done && due) begin
      slot_age[p] <= '0;
    end
  end

  // sequencer, marks and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      slot_acked    <= '0;
      slot_nacked   <= '0;
      slot_sent     <= '0;
      head_index    <= '0;
      slot_count    <= '0;
      last_seq      <= srsw_pkg::LAST_SEQ_RST;
      retired_bytes <= '0;
      accepted      <= 1'b0;
      k             <= '0;
      cmd_q         <= srsw_pkg::CMD_OFFER;
      seq_q         <= '0;
      len_q         <= '0;
      result_valid  <= 1'b0;
      result        <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          result_valid <= 1'b0;
          if (start) begin
            cmd_q    <= srsw_pkg::cmd_t'(item.cmd);
            seq_q    <= item.seq;
            len_q    <= item.frame_len;
            accepted <= 1'b0;
            k        <= '0;
            unique case (srsw_pkg::cmd_t'(item.cmd))
              srsw_pkg::CMD_OFFER: state <= S_OFFER;
              srsw_pkg::CMD_ACK:   state <= S_MARK;
              srsw_pkg::CMD_NACK:  state <= S_MARK;
              srsw_pkg::CMD_TICK:  state <= S_AGE;
              default:             state <= S_AGE;
            endcase
          end
        end
        S_OFFER: begin
          result_valid <= 1'b0;
          if (slot_count < win) begin
            last_seq            <= alu_rsp.res[srsw_pkg::SEQ_W-1:0];
            slot_acked[p_tail]  <= 1'b0;
            slot_nacked[p_tail] <= 1'b0;
            slot_sent[p_tail]   <= 1'b0;
            slot_count          <= slot_count + CW'(1);
            accepted            <= 1'b1;
          end
          state <= S_RETIRE;
        end
        S_MARK: begin
          result_valid <= 1'b0;
          // first held slot whose sequence matches
          if (walk_done) begin
            state <= S_RETIRE;
          end else if (alu_rsp.flag) begin
            slot_acked[p]  <= (cmd_q == srsw_pkg::CMD_ACK);
            slot_nacked[p] <= (cmd_q != srsw_pkg::CMD_ACK);
            state          <= S_RETIRE;
          end else begin
            k <= k + CW'(1);
          end
        end
        S_AGE: begin
          result_valid <= 1'b0;
          if (walk_done) begin
            state <= S_RETIRE;
          end else begin
            k <= k + CW'(1);
          end
        end
        S_RETIRE: begin
          result_valid <= 1'b0;
          // one leading acked slot a cycle
          if (slot_count != '0 && slot_acked[head_index]) begin
            retired_bytes           <= alu_rsp.res;
            slot_acked[head_index]  <= 1'b0;
            slot_nacked[head_index] <= 1'b0;
            slot_sent[head_index]   <= 1'b0;
            head_index              <= ring_add(head_index, IW'(1));
            slot_count              <= slot_count - CW'(1);
          end else begin
            k     <= '0;
            state <= S_SEND;
          end
        end
        S_SEND: begin
          if (walk_done) begin
            // status beat closes the event
            result_valid      <= 1'b1;
            result.kind       <= srsw_pkg::KIND_STATUS;
            result.tx_seq     <= '0;
            result.reason     <= srsw_pkg::WHY_FIRST;
            result.accepted   <= accepted;
            result.occupancy  <= srsw_pkg::OCC_W'(slot_count);
            result.bytes_done <= retired_bytes;
            result.last       <= 1'b1;
            state             <= S_IDLE;
          end else begin
            result_valid <= due;
            if (due) begin
              result.kind       <= srsw_pkg::KIND_TX;
              result.tx_seq     <= slot_seq[p];
              result.reason     <= why;
              result.accepted   <= 1'b0;
              result.occupancy  <= '0;
              result.bytes_done <= '0;
              result.last       <= 1'b0;
              slot_sent[p]      <= 1'b1;
              slot_nacked[p]    <= 1'b0;
            end
            k <= k + CW'(1);
          end
        end
        default: begin
          result_valid <= 1'b0;
          state        <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/selective_repeat_sender_window_top.sv]
// Throughput: one event at a time; busy stays high for the whole walk, set by the
//   single shared compare/add unit visiting one slot per cycle.
// Reset: synchronous, active high; empties the window, window 3 slots, timeout 1 tick.
// Results: one beat per cycle on result/result_valid, the receiver cannot stall.
// ---------------------------------------------------------------------------
// selective_repeat_sender_window_top: selective-repeat ARQ sender window
// Configuration registers, the slot sequencer and the shared arithmetic unit.
// ---------------------------------------------------------------------------
`default_nettype none

module selective_repeat_sender_window_top #(
  parameter int unsigned WIN_MAX = srsw_pkg::WIN_MAX_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  srsw_pkg::item_t                item,
  output logic                           result_valid,
  output srsw_pkg::result_t              result,
  input  logic                           cfg_we,
  input  logic [srsw_pkg::CFG_A_W-1:0]   cfg_addr,
  input  logic [srsw_pkg::CFG_W-1:0]     cfg_data
);

  srsw_pkg::cfg_t     cfg;
  srsw_pkg::alu_req_t alu_req;
  srsw_pkg::alu_rsp_t alu_rsp;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.win_slots     <= srsw_pkg::WINDOW_RST;
      cfg.timeout_ticks <= srsw_pkg::TIMEOUT_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        srsw_pkg::REG_WIN_SLOTS:     cfg.win_slots     <= cfg_data[srsw_pkg::WSZ_W-1:0];
        srsw_pkg::REG_TIMEOUT_TICKS: cfg.timeout_ticks <= cfg_data[srsw_pkg::TMO_W-1:0];
        default: ;
      endcase
    end
  end

  srsw_engine #(
    .WIN_MAX(WIN_MAX)
  ) u_engine (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .item        (item),
    .cfg         (cfg),
    .busy        (busy),
    .alu_req     (alu_req),
    .alu_rsp     (alu_rsp),
    .result_valid(result_valid),
    .result      (result)
  );

  srsw_alu u_alu (
    .req(alu_req),
    .rsp(alu_rsp)
  );

  // an accepted event keeps the block busy on the next cycle
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("event accepted but block not busy");

  // the status beat is issued as the sequencer returns to idle
  a_status_idle: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.last |-> !busy)
    else $error("status beat while still busy");

  // last marks exactly the status beat
  a_last_kind: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.last == (result.kind == srsw_pkg::KIND_STATUS)))
    else $error("last flag does not match result kind");

  // no beat comes out of an idle block that had no work
  a_no_stray: assert property (@(posedge clk) disable iff (rst)
    !busy && !$past(busy) |-> !result_valid)
    else $error("result beat without an event");

endmodule

`default_nettype wire
